/* src/ptcs_pkg.sv */
// Package for the pullup charge-time capacitive sensor.
// Widths, limits, register and status codes, FSM state type and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package ptcs_pkg;

  localparam int TOTAL_W  = 48;  // accumulated charge ticks
  localparam int PASS_W   = 32;  // calibration pass counter, baseline
  localparam int COUNT_W  = 16;  // sample count, cycle index
  localparam int MS_W     = 16;  // elapsed milliseconds
  localparam int CHARGE_W = 13;  // ticks within one charge cycle
  localparam int LIM_W    = 25;  // sample count * CAL_FACTOR
  localparam int PROD_W   = LIM_W + PASS_W;
  localparam int READ_W   = 30;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [CHARGE_W-1:0] READ_CHARGE_LIMIT = 13'd5000;
  localparam logic [CHARGE_W-1:0] CAL_CHARGE_LIMIT  = 13'd500;
  localparam logic [8:0]          CAL_FACTOR        = 9'd450;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [PASS_W-1:0]  PASS_MAX  = {PASS_W{1'b1}};
  localparam logic [MS_W-1:0]    MS_MAX    = {MS_W{1'b1}};
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TOTAL_W - 1);

  // register select is paddr[2]
  localparam logic REG_IDX_WINDOW = 1'b0;
  localparam logic REG_IDX_CLAMP  = 1'b1;
  localparam logic [MS_W-1:0] WINDOW_RESET = 16'd200;

  localparam logic [1:0] STATUS_NONE    = 2'd0;
  localparam logic [1:0] STATUS_OK      = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL_CHARGE,
    ST_CAL_DIS,
    ST_RD_CHARGE,
    ST_RD_DIS,
    ST_CAL_MUL,
    ST_CAL_CMP,
    ST_CAL_DIV
  } ptcs_state_t;

  typedef struct packed {
    logic count_ms;
    logic setup_cal;
    logic setup_read;
    logic charge;
    logic lim_cal;
    logic discharge;
    logic pass_end;
    logic mul;
    logic fail_set;
    logic fail_clr;
    logic div_start;
    logic base_load;
    logic emit;
    logic res_pin;
    logic res_done;
  } ptcs_cmd_t;

  typedef struct packed {
    logic need_cal;
    logic cycle_done;
    logic cycle_last;
    logic full_cal;
    logic full_rd;
    logic window_done;
    logic cal_over;
    logic div_busy;
  } ptcs_stat_t;

endpackage

`default_nettype wire

/* src/ptcs_div.sv */
// Iterative restoring divider: 48-bit dividend by 32-bit divisor,
// one quotient bit per cycle, low 32 quotient bits out. Uses ptcs_pkg.
`default_nettype none

module ptcs_div import ptcs_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [TOTAL_W-1:0] dividend,
  input  wire logic [PASS_W-1:0]  divisor,
  output logic                   busy,
  output logic [PASS_W-1:0]      quotient
);

  logic                 running;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [PASS_W-1:0]    rem;
  logic [TOTAL_W-1:0]   dq;
  logic [PASS_W:0]      rem_sh;
  logic [PASS_W:0]      rem_dif;
  logic                 fits;

  assign rem_sh  = {rem, dq[TOTAL_W-1]};
  assign fits    = rem_sh >= {1'b0, divisor};
  assign rem_dif = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      running  <= 1'b1;
      step_cnt <= '0;
    end else if (running) begin
      step_cnt <= step_cnt + 1'b1;
      if (step_cnt == DIV_LAST) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (running) begin
      rem <= fits ? rem_dif[PASS_W-1:0] : rem_sh[PASS_W-1:0];
      dq  <= {dq[TOTAL_W-2:0], fits};
    end
  end

  assign busy     = running;
  assign quotient = dq[PASS_W-1:0];

endmodule

`default_nettype wire

/* src/ptcs_dp.sv */
// Datapath: charge counters, totals, calibration state, limit multiplier,
// baseline divider and the result register. Uses ptcs_pkg, ptcs_div.
`default_nettype none

module ptcs_dp import ptcs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ptcs_cmd_t          ctl,
  output ptcs_stat_t              stat,
  input  wire logic [COUNT_W-1:0] sample_count,
  input  wire logic               pin_high,
  input  wire logic               ms_tick,
  input  wire logic [MS_W-1:0]    window_ms,
  input  wire logic               clamp_neg,
  output logic                    res_pin,
  output logic                    res_done,
  output logic signed [READ_W-1:0] res_reading,
  output logic [1:0]              res_status,
  output logic                    res_cal_failed
);

  logic [CHARGE_W-1:0] charge_ticks;
  logic [COUNT_W-1:0]  cycle_index;
  logic [TOTAL_W-1:0]  tick_total;
  logic [PASS_W-1:0]   pass_count;
  logic [MS_W-1:0]     elapsed_ms;
  logic [PASS_W-1:0]   baseline;
  logic                calibrated;
  logic [COUNT_W-1:0]  last_count;
  logic [LIM_W-1:0]    read_limit;   // last_count * CAL_FACTOR
  logic [PROD_W-1:0]   cal_limit;    // read_limit * pass_count
  logic                cal_fail_flag;

  logic [CHARGE_W-1:0] ct_inc;
  logic [CHARGE_W-1:0] lim;
  logic                full;
  logic [CHARGE_W-1:0] add_val;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_sat;
  logic [COUNT_W:0]    idx_inc;
  logic [MS_W-1:0]     elapsed_inc;
  logic                flag_next;
  logic                timeout;
  logic [TOTAL_W:0]    diff;
  logic [READ_W-1:0]   read_val;
  logic                div_busy;
  logic [PASS_W-1:0]   quotient;

  ptcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (tick_total),
    .divisor  (pass_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign ct_inc  = charge_ticks + 1'b1;
  assign lim     = ctl.lim_cal ? CAL_CHARGE_LIMIT : READ_CHARGE_LIMIT;
  assign full    = ct_inc >= lim;
  assign add_val = pin_high ? charge_ticks : lim;
  assign sum     = {1'b0, tick_total} + {{(TOTAL_W+1-CHARGE_W){1'b0}}, add_val};
  assign total_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign idx_inc = {1'b0, cycle_index} + 1'b1;
  assign elapsed_inc = (ms_tick && elapsed_ms != MS_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;

  assign stat.need_cal    = !calibrated || sample_count != last_count;
  assign stat.cycle_done  = cycle_index >= last_count;
  assign stat.cycle_last  = idx_inc >= {1'b0, last_count};
  assign stat.full_cal    = ct_inc >= CAL_CHARGE_LIMIT;
  assign stat.full_rd     = ct_inc >= READ_CHARGE_LIMIT;
  assign stat.window_done = elapsed_inc >= window_ms;
  assign stat.cal_over    = {{(PROD_W-TOTAL_W){1'b0}}, tick_total} >= cal_limit;
  assign stat.div_busy    = div_busy;

  always_comb begin
    flag_next = cal_fail_flag;
    if (ctl.fail_set) begin
      flag_next = 1'b1;
    end else if (ctl.fail_clr) begin
      flag_next = 1'b0;
    end
  end

  // reading at the end of a read pass
  assign timeout = tick_total >= {{(TOTAL_W-LIM_W){1'b0}}, read_limit};
  assign diff    = {1'b0, tick_total} - {{(TOTAL_W+1-PASS_W){1'b0}}, baseline};
  assign read_val = (clamp_neg && diff[TOTAL_W]) ? '0 : diff[READ_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_ticks  <= '0;
      cycle_index   <= '0;
      tick_total    <= '0;
      pass_count    <= '0;
      elapsed_ms    <= '0;
      baseline      <= '0;
      calibrated    <= 1'b0;
      last_count    <= '0;
      read_limit    <= '0;
      cal_fail_flag <= 1'b0;
    end else begin
      cal_fail_flag <= flag_next;

      if (ctl.setup_cal) begin
        last_count <= sample_count;
        read_limit <= LIM_W'({9'b0, sample_count} * {16'b0, CAL_FACTOR});
        calibrated <= 1'b1;
        pass_count <= '0;
      end else if (ctl.pass_end && pass_count != PASS_MAX) begin
        pass_count <= pass_count + 1'b1;
      end

      if (ctl.setup_cal) begin
        elapsed_ms <= '0;
      end else if (ctl.count_ms) begin
        elapsed_ms <= elapsed_inc;
      end

      if (ctl.setup_cal || ctl.setup_read) begin
        tick_total <= '0;
      end else if (ctl.charge && (pin_high || full)) begin
        tick_total <= total_sat;
      end

      priority if (ctl.setup_cal || ctl.setup_read || ctl.pass_end) begin
        cycle_index <= '0;
      end else if (ctl.discharge) begin
        cycle_index <= idx_inc[COUNT_W-1:0];
      end

      priority if (ctl.setup_cal || ctl.setup_read || ctl.pass_end || ctl.discharge) begin
        charge_ticks <= '0;
      end else if (ctl.charge && !pin_high) begin
        charge_ticks <= ct_inc;
      end

      if (ctl.base_load) begin
        baseline <= quotient;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      cal_limit <= {{(PROD_W-LIM_W){1'b0}}, read_limit} * {{(PROD_W-PASS_W){1'b0}}, pass_count};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res_pin        <= ctl.res_pin;
      res_done       <= ctl.res_done;
      res_cal_failed <= flag_next;
      if (!ctl.res_done) begin
        res_reading <= '0;
        res_status  <= STATUS_NONE;
      end else if (timeout) begin
        res_reading <= '1;
        res_status  <= STATUS_TIMEOUT;
      end else begin
        res_reading <= read_val;
        res_status  <= STATUS_OK;
      end
    end
  end

endmodule

`default_nettype wire

/* src/ptcs_ctrl.sv */
// Controller FSM: sequences calibration passes, read passes and the
// end-of-calibration multiply/compare/divide. Uses ptcs_pkg.
`default_nettype none

module ptcs_ctrl import ptcs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       cmd,
  input  wire logic       pin_high,
  input  wire ptcs_stat_t stat,
  output ptcs_cmd_t       ctl,
  output logic            busy
);

  ptcs_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.emit = 1'b1;
          if (cmd) begin
            if (stat.need_cal) begin
              ctl.setup_cal = 1'b1;
              state_next    = ST_CAL_CHARGE;
            end else begin
              ctl.setup_read = 1'b1;
              state_next     = ST_RD_CHARGE;
            end
          end
        end
      end
      ST_CAL_CHARGE: begin
        if (accept) begin
          ctl.count_ms = 1'b1;
          ctl.emit     = 1'b1;
          if (stat.cycle_done) begin
            ctl.pass_end = 1'b1;
            if (stat.window_done) begin
              ctl.emit   = 1'b0;
              state_next = ST_CAL_MUL;
            end
          end else begin
            ctl.charge  = 1'b1;
            ctl.lim_cal = 1'b1;
            ctl.res_pin = 1'b1;
            if (pin_high || stat.full_cal) begin
              state_next = ST_CAL_DIS;
            end
          end
        end
      end
      ST_CAL_DIS: begin
        if (accept) begin
          ctl.count_ms  = 1'b1;
          ctl.emit      = 1'b1;
          ctl.discharge = 1'b1;
          if (stat.cycle_last) begin
            ctl.pass_end = 1'b1;
            if (stat.window_done) begin
              ctl.emit   = 1'b0;
              state_next = ST_CAL_MUL;
            end else begin
              state_next = ST_CAL_CHARGE;
            end
          end else begin
            state_next = ST_CAL_CHARGE;
          end
        end
      end
      ST_RD_CHARGE: begin
        if (accept) begin
          ctl.emit = 1'b1;
          if (stat.cycle_done) begin
            ctl.res_done = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            ctl.charge  = 1'b1;
            ctl.res_pin = 1'b1;
            if (pin_high || stat.full_rd) begin
              state_next = ST_RD_DIS;
            end
          end
        end
      end
      ST_RD_DIS: begin
        if (accept) begin
          ctl.emit      = 1'b1;
          ctl.discharge = 1'b1;
          if (stat.cycle_last) begin
            ctl.res_done = 1'b1;
            state_next   = ST_IDLE;
          end else begin
            state_next = ST_RD_CHARGE;
          end
        end
      end
      ST_CAL_MUL: begin
        busy       = 1'b1;
        ctl.mul    = 1'b1;
        state_next = ST_CAL_CMP;
      end
      ST_CAL_CMP: begin
        busy = 1'b1;
        if (stat.cal_over) begin
          ctl.fail_set   = 1'b1;
          ctl.setup_read = 1'b1;
          ctl.emit       = 1'b1;
          state_next     = ST_RD_CHARGE;
        end else begin
          ctl.fail_clr  = 1'b1;
          ctl.div_start = 1'b1;
          state_next    = ST_CAL_DIV;
        end
      end
      ST_CAL_DIV: begin
        busy = 1'b1;
        if (!stat.div_busy) begin
          ctl.base_load  = 1'b1;
          ctl.setup_read = 1'b1;
          ctl.emit       = 1'b1;
          state_next     = ST_RD_CHARGE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/pullup_charge_time_cap_sensor.sv */
// Top level of the pullup charge-time capacitive sensor: APB registers,
// stream handshake and result valid. Uses ptcs_pkg, ptcs_ctrl, ptcs_dp.
`default_nettype none

// Each input transfer is one sampling tick (or a start command) and yields
// exactly one result transfer. A start measures the time the sense pin
// takes to charge through its pullup, sample_count times; the block first
// calibrates a baseline when uncalibrated or when the count changes, running
// whole passes until calibrate_window_ms milliseconds (counted from ms_tick)
// have passed. Throughput is one tick per clock while out_stall is low. The
// exception is the tick that closes calibration: a 25x32 limit multiply and
// compare (ST_CAL_MUL, ST_CAL_CMP) hold in_stall, and when calibration
// succeeds the 48-bit restoring divider that forms the baseline holds it in
// ST_CAL_DIV, one quotient bit a cycle. Results sit in an output register, so
// a new tick is taken in the cycle a pending result is transferred. Registers:
// 0x0 calibrate_window_ms, 0x4 clamp_negative; writes only while idle.

module pullup_charge_time_cap_sensor import ptcs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               cmd,
  input  wire logic [COUNT_W-1:0] sample_count,
  input  wire logic               pin_high,
  input  wire logic               ms_tick,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    pin_release,
  output logic                    done_res,
  output logic signed [READ_W-1:0] reading,
  output logic [1:0]              status,
  output logic                    cal_failed
);

  logic [MS_W-1:0] window_ms;
  logic            clamp_neg;
  logic            wr_en;
  logic            accept;
  logic            busy;
  ptcs_cmd_t       ctl;
  ptcs_stat_t      stat;

  // APB: zero wait states, register picked by paddr[2]
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_RESET;
      clamp_neg <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_IDX_WINDOW: window_ms <= pwdata[MS_W-1:0];
        REG_IDX_CLAMP:  clamp_neg <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_WINDOW: prdata = {{(DATA_W-MS_W){1'b0}}, window_ms};
      REG_IDX_CLAMP:  prdata = {{(DATA_W-1){1'b0}}, clamp_neg};
      default:        prdata = '0;
    endcase
  end

  // stall while the end-of-calibration arithmetic runs, or while a result
  // is still held by the downstream side
  assign in_stall = busy || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  ptcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (cmd),
    .pin_high (pin_high),
    .stat     (stat),
    .ctl      (ctl),
    .busy     (busy)
  );

  ptcs_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .stat           (stat),
    .sample_count   (sample_count),
    .pin_high       (pin_high),
    .ms_tick        (ms_tick),
    .window_ms      (window_ms),
    .clamp_neg      (clamp_neg),
    .res_pin        (pin_release),
    .res_done       (done_res),
    .res_reading    (reading),
    .res_status     (status),
    .res_cal_failed (cal_failed)
  );

endmodule

`default_nettype wire

/* sim/tb_pullup_charge_time_cap_sensor.sv */
// Self-checking testbench for pullup_charge_time_cap_sensor: random-gapped
// tick transfers in, one predicted result per tick checked on the way out.
// Depends on ptcs_pkg and the sensor RTL only.
`default_nettype none

module tb_pullup_charge_time_cap_sensor;
  timeunit 1ns;
  timeprecision 1ps;
  import ptcs_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int SHOWN_MAX   = 10;
  localparam int GAP_PCT     = 23;
  localparam int END_WAIT    = 64;

  // one tick as presented on the input channel
  typedef struct packed {
    logic               cmd;
    logic [COUNT_W-1:0] count;
    logic               pin;
    logic               ms;
  } sensor_item_t;

  // one result transfer
  typedef struct packed {
    logic              pin_release;
    logic              done;
    logic [READ_W-1:0] reading;
    logic [1:0]        status;
    logic              cal_failed;
  } sensor_result_t;

  // private copy of the sensor's state
  typedef struct packed {
    ptcs_state_t         phase;
    logic [CHARGE_W-1:0] charge;
    logic [COUNT_W-1:0]  cycle;
    logic [TOTAL_W-1:0]  total;
    logic [PASS_W-1:0]   passes;
    logic [MS_W-1:0]     ms;
    logic [PASS_W-1:0]   baseline;
    logic                calibrated;
    logic [COUNT_W-1:0]  last_count;
    logic                cal_fail;
  } sensor_state_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               in_valid, in_stall;
  logic               cmd, pin_high, ms_tick;
  logic [COUNT_W-1:0] sample_count;
  logic               out_valid, out_stall;
  logic               pin_release, done_res, cal_failed;
  logic signed [READ_W-1:0] reading;
  logic [1:0]         status;

  // register shadows, as the sensor should hold them
  logic [MS_W-1:0] cfg_window;
  logic            cfg_clamp;

  sensor_state_t  sensed_state;    // advanced on each accepted tick
  sensor_state_t  planned_state;   // advanced as ticks are queued
  sensor_item_t   tick_queue[$];
  sensor_result_t results_due[$];

  int  ticks_planned  = 0;
  int  ticks_accepted = 0;
  int  mismatches     = 0;
  int  cycle_count    = 0;
  bit  tick_taken     = 1'b0;  // set at the edge a tick transfers
  bit  calm           = 1'b0;  // no gaps or stalls while set

  pullup_charge_time_cap_sensor u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sample_count (sample_count),
    .pin_high     (pin_high),
    .ms_tick      (ms_tick),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pin_release  (pin_release),
    .done_res     (done_res),
    .reading      (reading),
    .status       (status),
    .cal_failed   (cal_failed)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Sensor behaviour
  // ---------------------------------------------------------------------

  // A calibration pass has run its last cycle. Once the window has passed
  // the baseline is settled (or the failure flagged) and the reading starts.
  function automatic void close_pass(inout sensor_state_t s);
    logic [63:0] cal_limit;
    if (s.passes != PASS_MAX) s.passes++;
    s.cycle  = '0;
    s.charge = '0;
    if (s.ms >= cfg_window) begin
      cal_limit = 64'(s.last_count) * 64'(CAL_FACTOR) * 64'(s.passes);
      if (64'(s.total) >= cal_limit) begin
        s.cal_fail = 1'b1;
      end else begin
        s.cal_fail = 1'b0;
        s.baseline = PASS_W'(64'(s.total) / 64'(s.passes));
      end
      s.total = '0;
      s.phase = ST_RD_CHARGE;
    end else begin
      s.phase = ST_CAL_CHARGE;
    end
  endfunction

  // Reading finished: timeout when the total reaches count*450, else the
  // difference to the baseline, floored at zero when clamping is on.
  function automatic void close_read(inout sensor_state_t s, inout sensor_result_t r);
    logic signed [63:0] diff;
    r.done = 1'b1;
    if (64'(s.total) >= 64'(s.last_count) * 64'(CAL_FACTOR)) begin
      r.reading = '1;
      r.status  = STATUS_TIMEOUT;
    end else begin
      diff = $signed({16'd0, s.total}) - $signed({32'd0, s.baseline});
      if (cfg_clamp && diff < 0) diff = '0;
      r.reading = diff[READ_W-1:0];
      r.status  = STATUS_OK;
    end
    s.phase = ST_IDLE;
  endfunction

  function automatic sensor_result_t sensor_tick(inout sensor_state_t s,
                                                 input sensor_item_t it);
    sensor_result_t      r;
    logic [CHARGE_W-1:0] cap;
    logic [TOTAL_W:0]    sum;
    logic                in_cal;
    r      = '0;
    in_cal = (s.phase == ST_CAL_CHARGE || s.phase == ST_CAL_DIS);
    if (in_cal && it.ms && s.ms != MS_MAX) s.ms++;
    case (s.phase)
      ST_IDLE: begin
        if (it.cmd) begin
          s.cycle  = '0;
          s.charge = '0;
          s.total  = '0;
          if (!s.calibrated || it.count != s.last_count) begin
            s.last_count = it.count;
            s.calibrated = 1'b1;
            s.passes     = '0;
            s.ms         = '0;
            s.phase      = ST_CAL_CHARGE;
          end else begin
            s.phase = ST_RD_CHARGE;
          end
        end
      end
      ST_CAL_CHARGE, ST_RD_CHARGE: begin
        cap = in_cal ? CAL_CHARGE_LIMIT : READ_CHARGE_LIMIT;
        if (s.cycle >= s.last_count) begin
          // zero sample count: the pass is a single empty tick
          if (in_cal) close_pass(s);
          else        close_read(s, r);
        end else begin
          r.pin_release = 1'b1;
          sum = '0;
          if (it.pin) begin
            sum = {1'b0, s.total} + (TOTAL_W+1)'(s.charge);
          end else begin
            s.charge++;
            if (s.charge >= cap) sum = {1'b0, s.total} + (TOTAL_W+1)'(cap);
          end
          if (it.pin || s.charge >= cap) begin
            s.total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
            s.phase = in_cal ? ST_CAL_DIS : ST_RD_DIS;
          end
        end
      end
      ST_CAL_DIS, ST_RD_DIS: begin
        s.charge = '0;
        s.cycle++;
        if (s.cycle >= s.last_count) begin
          if (in_cal) close_pass(s);
          else        close_read(s, r);
        end else begin
          s.phase = in_cal ? ST_CAL_CHARGE : ST_RD_CHARGE;
        end
      end
      default: s.phase = ST_IDLE;
    endcase
    r.cal_failed = s.cal_fail;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus planning: ticks are queued against planned_state, so the plan
  // always knows which phase the sensor will be in when a tick lands.
  // ---------------------------------------------------------------------

  task automatic plan_push(input sensor_item_t it);
    void'(sensor_tick(planned_state, it));
    tick_queue.push_back(it);
    ticks_planned++;
  endtask

  task automatic plan_idle(input int n);
    sensor_item_t it;
    repeat (n) begin
      it = {1'b0, COUNT_W'($urandom_range(65535)), 1'($urandom_range(1)),
            1'($urandom_range(1))};
      plan_push(it);
    end
  endtask

  // One start transfer, then ticks until the reading has completed. The
  // pin goes high with the given chance per tick, separately for the
  // calibration and the read; stray_pct injects starts while busy.
  task automatic plan_episode(input logic [COUNT_W-1:0] n_cycles, input int cal_pct,
                              input int read_pct, input int ms_pct, input int stray_pct);
    sensor_item_t it;
    int           pct;
    it = {1'b1, n_cycles, 1'($urandom_range(1)), 1'($urandom_range(1))};
    plan_push(it);
    while (planned_state.phase != ST_IDLE) begin
      pct = (planned_state.phase == ST_CAL_CHARGE ||
             planned_state.phase == ST_CAL_DIS) ? cal_pct : read_pct;
      it.cmd   = ($urandom_range(99) < stray_pct);
      it.count = COUNT_W'($urandom_range(65535));
      it.pin   = ($urandom_range(99) < pct);
      it.ms    = ($urandom_range(99) < ms_pct);
      plan_push(it);
    end
  endtask

  function automatic int pick_pct();
    case ($urandom_range(4))
      0:       return 5;
      1:       return 15;
      2:       return 35;
      3:       return 60;
      default: return 100;
    endcase
  endfunction

  // everything queued has transferred and every result has come back
  task automatic drain();
    while (ticks_accepted != ticks_planned || results_due.size() != 0)
      @(posedge clk);
  endtask

  // APB write: setup, access, completes on the edge with pready high
  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] value);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_IDX_WINDOW) cfg_window = value[MS_W-1:0];
    else                       cfg_clamp  = value[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Input driver: changes on the falling edge. A new tick is presented only
  // once the previous transfer has gone, so valid never follows stall.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    sensor_item_t nxt;
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < GAP_PCT);
      if (!in_valid || tick_taken) begin
        if (tick_queue.size() != 0 && (calm || $urandom_range(99) >= GAP_PCT)) begin
          nxt          = tick_queue.pop_front();
          cmd          <= nxt.cmd;
          sample_count <= nxt.count;
          pin_high     <= nxt.pin;
          ms_tick      <= nxt.ms;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      tick_taken = 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: samples both channels on the rising edge. Each input transfer
  // is run through the predictor; each result transfer is checked against
  // the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    sensor_result_t want, got;
    cycle_count++;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = sensor_tick(sensed_state, {cmd, sample_count, pin_high, ms_tick});
        results_due.push_back(want);
        ticks_accepted++;
        tick_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = {pin_release, done_res, reading, status, cal_failed};
        if (results_due.size() == 0) begin
          if (mismatches < SHOWN_MAX)
            $display("result transfer with nothing due: pin %0b done %0b reading %0d",
                     got.pin_release, got.done, $signed(got.reading));
          mismatches++;
        end else begin
          want = results_due.pop_front();
          if (got !== want) begin
            if (mismatches < SHOWN_MAX) begin
              $display("expected pin %0b done %0b reading %0d status %0d cal_failed %0b",
                       want.pin_release, want.done, $signed(want.reading),
                       want.status, want.cal_failed);
              $display("     got pin %0b done %0b reading %0d status %0d cal_failed %0b",
                       got.pin_release, got.done, $signed(got.reading),
                       got.status, got.cal_failed);
            end
            mismatches++;
          end
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pullup_charge_time_cap_sensor: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    int                 stop_at, r;
    logic [COUNT_W-1:0] n_cycles;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    cmd          = 1'b0;
    sample_count = '0;
    pin_high     = 1'b0;
    ms_tick      = 1'b0;
    out_stall    = 1'b0;
    cfg_window   = WINDOW_RESET;
    cfg_clamp    = 1'b0;
    sensed_state = '0;
    sensed_state.phase  = ST_IDLE;
    planned_state       = sensed_state;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // --- directed ---
    // idle ticks, then a first start under the reset window (200 ms)
    plan_idle(2);
    plan_episode(2, 40, 40, 100, 0);
    // same count again: straight to the read, no calibration
    plan_episode(2, 40, 50, 50, 0);
    // starts arriving mid-reading are plain ticks
    plan_episode(2, 30, 30, 50, 20);

    write_reg(REG_IDX_WINDOW, 32'd0);
    write_reg(REG_IDX_CLAMP, 32'd1);
    // zero count: calibration fails, reading times out
    plan_episode(16'd0, 50, 50, 50, 0);
    // pin never rises while calibrating: charge limit hit, cal fails
    plan_episode(16'd1, 0, 100, 50, 0);
    // slow calibration, fast read: negative reading floored at zero
    plan_episode(16'd3, 20, 100, 50, 0);

    write_reg(REG_IDX_WINDOW, 32'd1);
    write_reg(REG_IDX_CLAMP, 32'd0);
    // same count, fast read against the slow baseline: signed negative
    plan_episode(16'd3, 20, 100, 50, 0);

    // wider window: many passes before the baseline is divided out
    write_reg(REG_IDX_WINDOW, 32'd20);
    plan_episode(16'd1, 100, 100, 100, 0);

    // one pass, run without gaps or stalls
    write_reg(REG_IDX_WINDOW, 32'd0);
    calm = 1'b1;
    plan_episode(16'd16, 100, 100, 0, 0);
    plan_episode(16'd2, 35, 35, 50, 0);
    drain();
    calm = 1'b0;

    // --- random: several register settings, mostly whole readings ---
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_IDX_WINDOW, (s == 0) ? 32'd1 : DATA_W'($urandom_range(12)));
      write_reg(REG_IDX_CLAMP, DATA_W'(s % 2));
      stop_at = ticks_planned + 15;
      while (ticks_planned < stop_at) begin
        if ($urandom_range(99) < 20) plan_idle($urandom_range(1, 3));
        r = $urandom_range(99);
        if (r < 55)      n_cycles = planned_state.last_count;
        else if (r < 90) n_cycles = COUNT_W'($urandom_range(6));
        else             n_cycles = COUNT_W'($urandom_range(7, 16));
        plan_episode(n_cycles, pick_pct(), pick_pct(),
                     ($urandom_range(1) != 0) ? 80 : 30, 3);
      end
    end

    drain();
    repeat (END_WAIT) @(negedge clk);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("pullup_charge_time_cap_sensor: match");
    end else begin
      $display("pullup_charge_time_cap_sensor: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
